// ----- rtl/cfp_pkg.sv -----
// ----------------------------------------------------------------------------
// cfp_pkg
// Constants and header byte table for the command frame packer.
// ----------------------------------------------------------------------------
package cfp_pkg;

  localparam int FRAME_BYTES = 64;
  localparam int FO_W        = $clog2(FRAME_BYTES);
  localparam int LEN_W       = 14;
  localparam int HIDX_W      = 4;

  localparam logic [LEN_W-1:0]  MAX_LENGTH = LEN_W'(16383);
  localparam logic [LEN_W-1:0]  SHORT_MAX  = LEN_W'(63);
  localparam logic [FO_W-1:0]   FO_LAST    = FO_W'(FRAME_BYTES - 1);

  localparam logic [HIDX_W-1:0] HIDX_TAG        = HIDX_W'(6);
  localparam logic [HIDX_W-1:0] HIDX_LEN        = HIDX_W'(7);
  localparam logic [HIDX_W-1:0] HIDX_LEN_LO     = HIDX_W'(8);
  localparam logic [HIDX_W-1:0] HIDX_LAST_SHORT = HIDX_LEN;
  localparam logic [HIDX_W-1:0] HIDX_LAST_LONG  = HIDX_LEN_LO;

  localparam logic [7:0] TAG_BYTE = 8'h01;
  localparam logic [1:0] LEN_SHORT_MARK = 2'b10;
  localparam logic [1:0] LEN_LONG_MARK  = 2'b11;

  localparam logic [7:0] PRIMARY_HDR [6] = '{8'hff, 8'h08, 8'h00, 8'h01, 8'h01, 8'h02};

  typedef logic [7:0] byte_t;

  function automatic byte_t hdr_byte(input logic [HIDX_W-1:0] idx,
                                     input logic [LEN_W-1:0]  len);
    byte_t b;
    b = '0;
    if (idx < HIDX_TAG) begin
      b = PRIMARY_HDR[idx[2:0]];
    end else if (idx == HIDX_TAG) begin
      b = TAG_BYTE;
    end else if (idx == HIDX_LEN) begin
      if (len > SHORT_MAX) begin
        b = {LEN_LONG_MARK, len[13:8]};
      end else begin
        b = {LEN_SHORT_MARK, len[5:0]};
      end
    end else if (idx == HIDX_LEN_LO) begin
      b = len[7:0];
    end
    return b;
  endfunction

endpackage

// ----- rtl/command_frame_packer_top.sv -----
// ----------------------------------------------------------------------------
// command_frame_packer_top
// Frames command messages into zero-padded fixed-size frames.
// ----------------------------------------------------------------------------
// Input channel (in_*): one transaction per payload byte. The first transaction
// of a message carries in_first_item and the declared length; the final one
// carries in_last_item. Output channel (out_*): one transaction per stream
// byte, with frame, message and per-item end marks and a length mismatch flag
// on the message end byte.
// An accepted transaction sits in an input register; a sequencer emits its
// bytes one per cycle, while the output can advance, into an output register.
// A payload transaction yields one byte, and the next one is accepted as it
// leaves, so payload bytes stream back to back. A message opener emits a
// header of 8 or 9 bytes, then its payload byte if the length is nonzero;
// a closing transaction adds padding bytes, up to a full frame. A transaction
// that yields no byte still occupies the sequencer. The next transaction is
// accepted in the cycle that the current item's final byte moves to the
// output register. While a byte is held and out_ready is low, the output
// register holds and the sequencer and in_ready stall with it.
// Reset clears all control state and leaves the block idle outside a message.
// ----------------------------------------------------------------------------
module command_frame_packer_top
  import cfp_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       in_data_byte,
  input  logic [LEN_W-1:0] in_message_length,
  input  logic             in_first_item,
  input  logic             in_last_item,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_out_byte,
  output logic             out_frame_end,
  output logic             out_message_end,
  output logic             out_run_end,
  output logic             out_length_mismatch
);

  localparam logic [2:0] ST_START = 3'd0;
  localparam logic [2:0] ST_HDR   = 3'd1;
  localparam logic [2:0] ST_PAY   = 3'd2;
  localparam logic [2:0] ST_PAD   = 3'd3;
  localparam logic [2:0] ST_DROP  = 3'd4;

  logic             hv_r;
  logic [7:0]       h_data_r;
  logic [LEN_W-1:0] h_len_r;
  logic             h_first_r;
  logic             h_last_r;

  logic [2:0]        ph_r, ph_nxt;
  logic [HIDX_W-1:0] hidx_r, hidx_nxt;
  logic              em_r;

  logic [FO_W-1:0]  fo_r;
  logic [LEN_W-1:0] bl_r;
  logic             msg_r;
  logic             cerr_r;

  logic       out_valid_r;
  byte_t      out_byte_r;
  logic       out_fe_r, out_me_r, out_re_r, out_lm_r;

  logic [2:0]        kind;
  logic              start_hdr;
  logic [LEN_W-1:0]  len_sat;
  logic              len_over;
  logic [HIDX_W-1:0] idx, hdr_last_idx;
  logic [FO_W-1:0]   fo_cur, fo_after, fo_new;
  logic [LEN_W-1:0]  bl_cur, bl_after;
  logic              cerr_cur, cerr_eff, pay_err;
  logic              fe, emit, done, mend, tail;
  byte_t             b;
  logic              adv, fire, in_acc;

  assign adv    = !out_valid_r || out_ready;
  assign fire   = hv_r && adv;
  assign in_ready = !hv_r || (adv && done);
  assign in_acc = in_valid && in_ready;

  assign len_over     = h_len_r > MAX_LENGTH;
  assign len_sat      = len_over ? MAX_LENGTH : h_len_r;
  assign hdr_last_idx = (len_sat > SHORT_MAX) ? HIDX_LAST_LONG : HIDX_LAST_SHORT;

  always_comb begin
    if (ph_r == ST_START) begin
      if (msg_r) begin
        kind = ST_PAY;
      end else if (h_first_r) begin
        kind = ST_HDR;
      end else begin
        kind = ST_DROP;
      end
    end else begin
      kind = ph_r;
    end
  end

  assign start_hdr = (ph_r == ST_START) && (kind == ST_HDR);
  assign idx       = start_hdr ? '0 : hidx_r;
  assign fo_cur    = start_hdr ? '0 : fo_r;
  assign bl_cur    = start_hdr ? len_sat : bl_r;
  assign cerr_cur  = start_hdr ? len_over : cerr_r;
  assign fe        = fo_cur == FO_LAST;
  assign fo_after  = fe ? '0 : FO_W'(fo_cur + 1'b1);
  assign fo_new    = emit ? fo_after : fo_cur;

  always_comb begin
    emit     = 1'b0;
    b        = '0;
    done     = 1'b0;
    mend     = 1'b0;
    tail     = 1'b0;
    pay_err  = 1'b0;
    bl_after = bl_cur;
    ph_nxt   = ph_r;
    hidx_nxt = hidx_r;
    unique case (kind)
      ST_HDR: begin
        emit   = 1'b1;
        b      = hdr_byte(idx, len_sat);
        ph_nxt = ST_HDR;
        hidx_nxt = HIDX_W'(idx + 1'b1);
        if (idx == hdr_last_idx) begin
          if (len_sat != '0) begin
            ph_nxt = ST_PAY;
          end else begin
            tail = 1'b1;
          end
        end
      end
      ST_PAY: begin
        tail = 1'b1;
        if (bl_cur != '0) begin
          emit     = 1'b1;
          b        = h_data_r;
          bl_after = LEN_W'(bl_cur - 1'b1);
        end else begin
          pay_err = 1'b1;
        end
      end
      ST_PAD: begin
        emit = 1'b1;
        if (fo_after == '0) begin
          mend = 1'b1;
          done = 1'b1;
        end
      end
      default: begin
        done = 1'b1;
      end
    endcase
    if (tail) begin
      if (!h_last_r) begin
        done = 1'b1;
      end else if ((em_r || emit) && (emit ? fo_after : fo_cur) == '0) begin
        mend = 1'b1;
        done = 1'b1;
      end else begin
        ph_nxt = ST_PAD;
      end
    end
  end

  assign cerr_eff = cerr_cur || pay_err || (tail && h_last_r && bl_after != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hv_r        <= 1'b0;
      ph_r        <= ST_START;
      hidx_r      <= '0;
      em_r        <= 1'b0;
      fo_r        <= '0;
      bl_r        <= '0;
      msg_r       <= 1'b0;
      cerr_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        hv_r <= 1'b1;
      end else if (fire && done) begin
        hv_r <= 1'b0;
      end
      if (fire) begin
        fo_r <= fo_new;
        if (mend) begin
          msg_r  <= 1'b0;
          bl_r   <= '0;
          cerr_r <= 1'b0;
        end else begin
          msg_r  <= msg_r || start_hdr;
          bl_r   <= bl_after;
          cerr_r <= cerr_eff;
        end
        if (done) begin
          ph_r   <= ST_START;
          hidx_r <= '0;
          em_r   <= 1'b0;
        end else begin
          ph_r   <= ph_nxt;
          hidx_r <= hidx_nxt;
          em_r   <= em_r || emit;
        end
      end
      if (adv) begin
        out_valid_r <= fire && emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      h_data_r  <= in_data_byte;
      h_len_r   <= in_message_length;
      h_first_r <= in_first_item;
      h_last_r  <= in_last_item;
    end
    if (fire && emit) begin
      out_byte_r <= b;
      out_fe_r   <= fe;
      out_me_r   <= mend;
      out_re_r   <= done;
      out_lm_r   <= mend && cerr_eff;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_out_byte        = out_byte_r;
  assign out_frame_end       = out_fe_r;
  assign out_message_end     = out_me_r;
  assign out_run_end         = out_re_r;
  assign out_length_mismatch = out_lm_r;

endmodule

// ----- dv/tb_command_frame_packer_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_command_frame_packer_top
// Self-checking bench for the command frame packer. A queue of command
// transactions (directed corner cases, then random well-formed and broken
// messages) feeds a valid/ready driver. Each accepted transaction runs
// through a behavioral packer that queues the expected stream bytes. A
// monitor compares every output transaction against that queue while both
// sides idle and stall in several patterns.
// ----------------------------------------------------------------------------
module tb_command_frame_packer_top;
  import cfp_pkg::*;

  typedef enum logic [1:0] {
    PH_FREE,
    PH_SRC_IDLE,
    PH_SNK_STALL,
    PH_BOTH
  } idle_phase_t;

  typedef struct packed {
    logic [7:0]       data;
    logic [LEN_W-1:0] len;
    logic             first;
    logic             last;
    idle_phase_t      phase;
    logic             drain;
    logic             rx_hold;
  } cmd_item_t;

  typedef struct packed {
    logic [7:0] data;
    logic       frame_end;
    logic       message_end;
    logic       run_end;
    logic       mismatch;
  } stream_byte_t;

  localparam int         SRC_IDLE_PCT  = 84;
  localparam int         SNK_STALL_PCT = 84;
  localparam int         BOTH_IDLE_PCT = 13;
  localparam int         HOLD_CYCLES   = 300;
  localparam int         TAIL_CYCLES   = 200;
  localparam int         RAND_ITEMS    = 85;
  localparam int         MAX_RUN       = 80;
  localparam logic [7:0] PAD_BYTE      = 8'h00;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [7:0]       in_data_byte = '0;
  logic [LEN_W-1:0] in_message_length = '0;
  logic             in_first_item = 1'b0;
  logic             in_last_item = 1'b0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [7:0]       out_out_byte;
  logic             out_frame_end;
  logic             out_message_end;
  logic             out_run_end;
  logic             out_length_mismatch;

  command_frame_packer_top u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_data_byte        (in_data_byte),
    .in_message_length   (in_message_length),
    .in_first_item       (in_first_item),
    .in_last_item        (in_last_item),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_out_byte        (out_out_byte),
    .out_frame_end       (out_frame_end),
    .out_message_end     (out_message_end),
    .out_run_end         (out_run_end),
    .out_length_mismatch (out_length_mismatch)
  );

  cmd_item_t    cmd_items_q [$];
  stream_byte_t frame_bytes_q [$];
  cmd_item_t    offered_item;
  idle_phase_t  tx_phase = PH_FREE;
  logic         hold_kick = 1'b0;
  int           hold_left = 0;

  int n_fail = 0;
  int n_checked = 0;
  int n_accepted = 0;
  int n_built = 0;
  int n_msgs = 0;
  int n_flagged = 0;

  // packer state
  logic [FO_W-1:0]  pk_offset = '0;
  logic [LEN_W-1:0] pk_left = '0;
  logic             pk_open = 1'b0;
  logic             pk_err = 1'b0;
  stream_byte_t     run_buf [0:MAX_RUN-1];
  int               run_len;

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("%0t timeout with %0d bytes still expected", $time, frame_bytes_q.size());
    $display("tb: failure");
    $finish;
  end

  task automatic put_byte(input logic [7:0] b);
    stream_byte_t s;
    s.data        = b;
    s.frame_end   = (pk_offset == FO_LAST);
    s.message_end = 1'b0;
    s.run_end     = 1'b0;
    s.mismatch    = 1'b0;
    run_buf[run_len] = s;
    run_len++;
    pk_offset = (pk_offset == FO_LAST) ? '0 : pk_offset + 1'b1;
  endtask

  task automatic take_payload(input logic [7:0] b);
    if (pk_left != 0) begin
      put_byte(b);
      pk_left = pk_left - 1'b1;
    end else begin
      pk_err = 1'b1;
    end
  endtask

  task automatic frame_command_item(input cmd_item_t it);
    stream_byte_t s;
    int           k;
    run_len = 0;
    if (pk_open || it.first) begin
      if (!pk_open) begin
        pk_open   = 1'b1;
        pk_err    = 1'b0;
        pk_offset = '0;
        for (k = 0; k < $size(PRIMARY_HDR); k++) begin
          put_byte(PRIMARY_HDR[k]);
        end
        put_byte(TAG_BYTE);
        if (it.len > SHORT_MAX) begin
          put_byte({LEN_LONG_MARK, it.len[13:8]});
          put_byte(it.len[7:0]);
        end else begin
          put_byte({LEN_SHORT_MARK, it.len[5:0]});
        end
        pk_left = it.len;
        if (it.len != 0) begin
          take_payload(it.data);
        end
      end else begin
        take_payload(it.data);
      end
      if (it.last) begin
        if (pk_left != 0) begin
          pk_err = 1'b1;
        end
        // pad to the frame end, or a whole frame when nothing else is left to mark the end
        if (run_len == 0 || pk_offset != 0) begin
          put_byte(PAD_BYTE);
          while (pk_offset != 0) begin
            put_byte(PAD_BYTE);
          end
        end
        s = run_buf[run_len-1];
        s.message_end = 1'b1;
        s.mismatch    = pk_err;
        run_buf[run_len-1] = s;
        if (pk_err) begin
          n_flagged++;
        end
        pk_open = 1'b0;
        pk_left = '0;
        pk_err  = 1'b0;
      end
      if (run_len > 0) begin
        s = run_buf[run_len-1];
        s.run_end = 1'b1;
        run_buf[run_len-1] = s;
      end
      for (k = 0; k < run_len; k++) begin
        frame_bytes_q.push_back(run_buf[k]);
      end
    end
  endtask

  // fill < 0 picks random payload bytes
  task automatic queue_message(input int declared, input int sent, input int stray_at,
                               input int fill, input idle_phase_t ph, input bit drain,
                               input bit hold);
    cmd_item_t it;
    int        i;
    for (i = 0; i < sent; i++) begin
      it.data    = (fill < 0) ? 8'($urandom_range(255)) : 8'(fill);
      it.len     = (i == 0) ? LEN_W'(declared) : LEN_W'($urandom_range(16383));
      it.first   = (i == 0) || (i == stray_at);
      it.last    = (i == sent - 1);
      it.phase   = ph;
      it.drain   = drain && (i == 0);
      it.rx_hold = hold && (i == 0);
      cmd_items_q.push_back(it);
    end
    n_built += sent;
    n_msgs++;
  endtask

  task automatic queue_stray(input idle_phase_t ph, input bit drain, input int last_mark);
    cmd_item_t it;
    it.data    = 8'($urandom_range(255));
    it.len     = LEN_W'($urandom_range(16383));
    it.first   = 1'b0;
    it.last    = (last_mark < 0) ? 1'($urandom_range(1)) : 1'(last_mark);
    it.phase   = ph;
    it.drain   = drain;
    it.rx_hold = 1'b0;
    cmd_items_q.push_back(it);
    n_built++;
  endtask

  always @(posedge clk) begin : driver_proc
    cmd_item_t nxt;
    logic      go;
    logic      kick;
    kick = 1'b0;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        frame_command_item(offered_item);
        n_accepted++;
      end
      if (!in_valid || in_ready) begin
        go = (cmd_items_q.size() != 0);
        if (go) begin
          nxt = cmd_items_q[0];
          if (nxt.drain && frame_bytes_q.size() != 0) begin
            go = 1'b0;
          end else if (nxt.phase == PH_SRC_IDLE) begin
            go = ($urandom_range(99) >= SRC_IDLE_PCT);
          end else if (nxt.phase == PH_BOTH) begin
            go = ($urandom_range(99) >= BOTH_IDLE_PCT);
          end
        end
        if (go) begin
          nxt = cmd_items_q.pop_front();
          offered_item = nxt;
          in_data_byte      <= nxt.data;
          in_message_length <= nxt.len;
          in_first_item     <= nxt.first;
          in_last_item      <= nxt.last;
          in_valid          <= 1'b1;
          tx_phase          <= nxt.phase;
          kick = nxt.rx_hold;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
    hold_kick <= kick;
  end

  always @(posedge clk) begin : hold_proc
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_kick) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin : monitor_proc
    stream_byte_t got;
    stream_byte_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got.data        = out_out_byte;
        got.frame_end   = out_frame_end;
        got.message_end = out_message_end;
        got.run_end     = out_run_end;
        got.mismatch    = out_length_mismatch;
        if (frame_bytes_q.size() == 0) begin
          $display("%0t unexpected byte=%02h fe=%0b me=%0b re=%0b lm=%0b", $time,
                   got.data, got.frame_end, got.message_end, got.run_end, got.mismatch);
          n_fail++;
        end else begin
          want = frame_bytes_q.pop_front();
          n_checked++;
          if (got !== want) begin
            $display("%0t mismatch: expected byte=%02h fe=%0b me=%0b re=%0b lm=%0b",
                     $time, want.data, want.frame_end, want.message_end, want.run_end,
                     want.mismatch);
            $display("%0t           actual   byte=%02h fe=%0b me=%0b re=%0b lm=%0b",
                     $time, got.data, got.frame_end, got.message_end, got.run_end,
                     got.mismatch);
            n_fail++;
          end
        end
      end
      if (hold_left != 0) begin
        out_ready <= 1'b0;
      end else if (tx_phase == PH_SNK_STALL) begin
        out_ready <= ($urandom_range(99) >= SNK_STALL_PCT);
      end else if (tx_phase == PH_BOTH) begin
        out_ready <= ($urandom_range(99) >= BOTH_IDLE_PCT);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : main_seq
    int          rand_start;
    int          idx;
    int          pick;
    int          declared;
    int          sent;
    idle_phase_t ph;
    idle_phase_t last_ph;

    // directed corner cases
    queue_stray(PH_FREE, 1'b0, 1);
    queue_stray(PH_FREE, 1'b0, 0);
    queue_message(0, 1, -1, 8'hff, PH_FREE, 1'b0, 1'b0);
    queue_message(1, 1, -1, 8'h00, PH_FREE, 1'b0, 1'b0);
    queue_message(1, 1, -1, 8'hff, PH_FREE, 1'b0, 1'b0);
    queue_message(63, 2, -1, -1, PH_FREE, 1'b0, 1'b0);
    queue_message(64, 1, -1, -1, PH_FREE, 1'b0, 1'b0);
    queue_message(16383, 1, -1, 8'hff, PH_FREE, 1'b0, 1'b0);
    queue_message(3, 3, 1, -1, PH_FREE, 1'b0, 1'b0);
    queue_message(1, 3, -1, -1, PH_FREE, 1'b0, 1'b0);
    queue_message(0, 2, -1, -1, PH_FREE, 1'b0, 1'b0);
    queue_message(4, 4, -1, -1, PH_FREE, 1'b0, 1'b0);

    // fill a frame exactly, then close with a surplus byte on the boundary;
    // the receiver holds off meanwhile so the input backs up
    queue_message(56, 57, -1, -1, PH_FREE, 1'b1, 1'b1);

    rand_start = n_built;
    last_ph = PH_FREE;
    while (n_built < rand_start + RAND_ITEMS) begin
      idx = ((n_built - rand_start) * 4) / RAND_ITEMS;
      if (idx > 3) begin
        idx = 3;
      end
      ph = idle_phase_t'(idx[1:0]);
      pick = $urandom_range(99);
      if (pick < 8) begin
        queue_stray(ph, ph != last_ph, -1);
      end else if (pick < 75) begin
        declared = ($urandom_range(3) == 0) ? $urandom_range(30, 11) : $urandom_range(10, 0);
        sent = (declared == 0) ? 1 : declared;
        queue_message(declared, sent, -1, -1, ph, ph != last_ph, 1'b0);
      end else if (pick < 85) begin
        declared = $urandom_range(16383, 2);
        sent = $urandom_range((declared > 7) ? 6 : declared - 1, 1);
        queue_message(declared, sent, -1, -1, ph, ph != last_ph, 1'b0);
      end else if (pick < 93) begin
        declared = $urandom_range(6, 0);
        sent = ((declared == 0) ? 1 : declared) + $urandom_range(3, 1);
        queue_message(declared, sent, -1, -1, ph, ph != last_ph, 1'b0);
      end else begin
        declared = $urandom_range(8, 2);
        queue_message(declared, declared, $urandom_range(declared - 1, 1), -1, ph,
                      ph != last_ph, 1'b0);
      end
      last_ph = ph;
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (cmd_items_q.size() != 0 || in_valid) begin
      @(posedge clk);
    end
    while (frame_bytes_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (TAIL_CYCLES) @(posedge clk);

    if (frame_bytes_q.size() != 0) begin
      $display("%0t %0d expected bytes never arrived", $time, frame_bytes_q.size());
      n_fail++;
    end
    $display("covered %0d input transactions in %0d messages, %0d of them flagged",
             n_accepted, n_msgs, n_flagged);
    $display("checked %0d output bytes across free, idle, stall and hold-off phases",
             n_checked);
    if (n_fail == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
